/* hw/rtl/imaenc_pkg.sv */
`default_nettype none

package imaenc_pkg;

  // Step index range and predictor limits
  localparam logic [6:0]  IDX_MAX  = 7'd88;
  localparam logic [15:0] PRED_MAX = 16'h7fff;
  localparam logic [15:0] PRED_MIN = 16'h8000;

  // Nibble masks used when packing
  localparam logic [7:0] HI_MASK = 8'hf0;
  localparam logic [7:0] LO_MASK = 8'h0f;

  typedef logic [14:0] step_t;
  typedef logic [6:0]  idx_t;
  typedef logic [3:0]  code_t;

  // One encoded code on its way to the packer
  typedef struct packed {
    code_t code;
    logic  last;
  } code_beat_t;

  // Packer status back to the pipeline control
  typedef struct packed {
    logic stall;
    logic advance;
  } pack_stat_t;

  // Step size table; indexes past 87 read as 32767
  function automatic step_t step_size(input idx_t idx);
    step_t s;
    case (idx)
      7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
      7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
      7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
      7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
      7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
      7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
      7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
      7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
      7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
      7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
      7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
      7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
      7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
      7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
      7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
      7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
      7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
      7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
      7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
      7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
      7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
      7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
      7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
      7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
      7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
      7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
      7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
      7'd87: s = 15'd29794;
      default: s = 15'd32767;
    endcase
    return s;
  endfunction

  // Index adjustment by magnitude bits
  function automatic logic signed [7:0] idx_adjust(input logic [2:0] mag);
    logic signed [7:0] a;
    case (mag)
      3'd4:    a = 8'sd2;
      3'd5:    a = 8'sd4;
      3'd6:    a = 8'sd6;
      3'd7:    a = 8'sd8;
      default: a = -8'sd1;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/imaenc_core.sv */
`default_nettype none

module imaenc_core (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [15:0]            sample,
  input  wire logic                   last,
  input  wire logic                   advance,
  output imaenc_pkg::code_beat_t      beat
);

  logic signed [15:0] pred_r, pred_nxt;
  imaenc_pkg::idx_t   idx_r, idx_nxt;

  imaenc_pkg::step_t  step;
  logic [16:0]        diff;
  logic               sign;
  logic [15:0]        mag0, mag1, mag2;
  logic               b2, b1, b0;
  logic [15:0]        vpdiff;
  logic [17:0]        pred_sum;
  logic signed [7:0]  idx_sum;

  // Difference against predictor, sign and magnitude
  always_comb begin
    step = imaenc_pkg::step_size(idx_r);
    diff = {sample[15], sample} - {pred_r[15], pred_r};
    sign = diff[16];
    mag0 = sign ? 16'(17'd0 - diff) : diff[15:0];
  end

  // Three compare-subtract stages: step, step/2, step/4
  always_comb begin
    b2   = mag0 >= {1'b0, step};
    mag1 = b2 ? (mag0 - {1'b0, step}) : mag0;
    b1   = mag1 >= {2'b0, step[14:1]};
    mag2 = b1 ? (mag1 - {2'b0, step[14:1]}) : mag1;
    b0   = mag2 >= {3'b0, step[14:2]};
  end

  // Reconstructed difference and clamped predictor update
  always_comb begin
    vpdiff = {4'b0, step[14:3]}
           + (b2 ? {1'b0, step} : 16'd0)
           + (b1 ? {2'b0, step[14:1]} : 16'd0)
           + (b0 ? {3'b0, step[14:2]} : 16'd0);
    pred_sum = sign ? ({{2{pred_r[15]}}, pred_r} - {2'b0, vpdiff})
                    : ({{2{pred_r[15]}}, pred_r} + {2'b0, vpdiff});
    if (pred_sum[17:15] == 3'b000 || pred_sum[17:15] == 3'b111) begin
      pred_nxt = pred_sum[15:0];
    end else if (pred_sum[17]) begin
      pred_nxt = imaenc_pkg::PRED_MIN;
    end else begin
      pred_nxt = imaenc_pkg::PRED_MAX;
    end
  end

  // Step index update, clamped to 0..88
  always_comb begin
    idx_sum = $signed({1'b0, idx_r}) + imaenc_pkg::idx_adjust({b2, b1, b0});
    if (idx_sum[7]) begin
      idx_nxt = '0;
    end else if (idx_sum[6:0] > imaenc_pkg::IDX_MAX) begin
      idx_nxt = imaenc_pkg::IDX_MAX;
    end else begin
      idx_nxt = idx_sum[6:0];
    end
  end

  assign beat.code = {sign, b2, b1, b0};
  assign beat.last = last;

  // Encoder state, carried across runs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pred_r <= '0;
      idx_r  <= '0;
    end else if (advance) begin
      pred_r <= pred_nxt;
      idx_r  <= idx_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/imaenc_pack.sv */
`default_nettype none

module imaenc_pack (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   beat_valid,
  input  wire imaenc_pkg::code_beat_t beat,
  output imaenc_pkg::pack_stat_t      stat,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [7:0]                  out_code_byte,
  output logic                        out_byte_last
);

  logic                  low_nibble_r;
  imaenc_pkg::code_t     held_code_r;
  logic                  out_valid_r;
  logic [7:0]            byte_r, byte_nxt;
  logic                  blast_r;
  logic                  emit;

  // A byte goes out on the second code of a pair or on a run end
  assign emit         = low_nibble_r || beat.last;
  assign stat.stall   = emit && out_valid_r && !out_ready;
  assign stat.advance = beat_valid && !stat.stall;

  always_comb begin
    if (low_nibble_r) begin
      byte_nxt = ({held_code_r, 4'b0} & imaenc_pkg::HI_MASK)
               | ({4'b0, beat.code} & imaenc_pkg::LO_MASK);
    end else begin
      byte_nxt = {beat.code, 4'b0} & imaenc_pkg::HI_MASK;
    end
  end

  // Pairing state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_nibble_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (stat.advance) begin
        low_nibble_r <= !low_nibble_r && !beat.last;
      end
      if (stat.advance && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    if (stat.advance && !low_nibble_r) begin
      held_code_r <= beat.code;
    end
    if (stat.advance && emit) begin
      byte_r  <= byte_nxt;
      blast_r <= beat.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_code_byte = byte_r;
  assign out_byte_last = blast_r;

endmodule

`default_nettype wire

/* hw/rtl/ima_adpcm_encoder.sv */
`default_nettype none

// IMA ADPCM 4-bit encoder with nibble packing.
// Input channel (in_valid/in_ready): one signed 16-bit PCM sample per beat,
// with in_last_sample marking the final sample of a run.
// Output channel (out_valid/out_ready): one byte per two samples, earlier
// code in bits 7..4; out_byte_last marks the byte that ends a run. A run
// with an odd sample count ends in a byte whose low nibble is zero.
// A sample is held in the input register while it is encoded; the byte it
// completes is then registered and shown on out_*.
// Throughput: one sample per cycle while the output is not stalled. The
// whole encode step (compare-subtract chain, predictor clamp, index table)
// sits between the input register and the state/output registers.
// Reset (rst_n low, synchronous) clears predictor and step index to zero
// and restarts packing at the high nibble. Predictor and index otherwise
// carry across runs.
// When the receiver stalls, the held byte stays on out_*; one more sample
// is still taken into the input register, and a sample that does not
// complete a byte is encoded without waiting for the output.

module ima_adpcm_encoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_sample,
  input  wire logic        in_last_sample,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_code_byte,
  output logic             out_byte_last
);

  logic                    in_valid_r;
  logic [15:0]             sample_r;
  logic                    last_r;
  imaenc_pkg::code_beat_t  beat;
  imaenc_pkg::pack_stat_t  stat;

  // Input register frees up whenever its beat moves on
  assign in_ready = !in_valid_r || stat.advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      sample_r <= in_sample;
      last_r   <= in_last_sample;
    end
  end

  imaenc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .sample  (sample_r),
    .last    (last_r),
    .advance (stat.advance),
    .beat    (beat)
  );

  imaenc_pack u_pack (
    .clk           (clk),
    .rst_n         (rst_n),
    .beat_valid    (in_valid_r),
    .beat          (beat),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_code_byte (out_code_byte),
    .out_byte_last (out_byte_last)
  );

endmodule

`default_nettype wire

/* hw/rtl/imaenc_checker.sv */
`default_nettype none

module imaenc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_code_byte,
  input wire logic       out_byte_last
);

  // Reset empties the output register
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // With the output free or draining, the input side never stalls
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
      (!out_valid || out_ready) |-> in_ready)
    else $error("in_ready low while output can move");

  // A stalled byte stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped before accept");

  // A stalled byte keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_ready |=> $stable(out_code_byte) && $stable(out_byte_last))
    else $error("output payload changed during stall");

endmodule

bind ima_adpcm_encoder imaenc_checker u_imaenc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_code_byte (out_code_byte),
  .out_byte_last (out_byte_last)
);

`default_nettype wire
